// File: design/nearby_vehicle_proximity_table_unit_defines.svh
// Assertion macros shared by the proximity table modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef NEARBY_VEHICLE_PROXIMITY_TABLE_UNIT_DEFINES_SVH
`define NEARBY_VEHICLE_PROXIMITY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NVP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/nvpt_pkg.sv
`timescale 1ns / 1ps

package nvpt_pkg;

  // Operation codes carried in tuser.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NEAR_LIMIT = 2'd0;
  localparam logic [1:0] CFG_FAR_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_STALE_TMO  = 2'd2;

  // Alert levels.
  localparam logic [1:0] ALERT_NEAR = 2'd0;
  localparam logic [1:0] ALERT_MID  = 2'd1;
  localparam logic [1:0] ALERT_FAR  = 2'd2;

  // Minimum reported when no occupied entry is nearer.
  localparam logic [23:0] NO_VEHICLE_DIST = 24'd10000000;

  // Reset values of the configuration registers.
  localparam logic [23:0] NEAR_LIMIT_RST = 24'd50;
  localparam logic [23:0] FAR_LIMIT_RST  = 24'd100;
  localparam logic [31:0] STALE_TMO_RST  = 32'd12000;

  typedef struct packed {
    logic [7:0]  id;
    logic [23:0] distance;
    logic [31:0] seen;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // capture the input item, reset accumulators
    logic rd_en;  // read one table entry
    logic fold;   // apply the report write and fold its distance into the minimum
    logic emit;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } sts_t;

endpackage

// File: design/nvpt_ctrl.sv
`timescale 1ns / 1ps
`include "nearby_vehicle_proximity_table_unit_defines.svh"

module nvpt_ctrl
  import nvpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 8,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sts_t             sts_i,
  output cmd_t             cmd_o,
  output logic [IDX_W-1:0] rd_addr_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `NVP_ASSERT_NEXT(a_accept_starts_scan, in_valid_i && in_ready_o, state_q == ST_SCAN, "accepted item did not start a scan")
  `NVP_ASSERT_IMP(a_emit_only_when_free, cmd_o.emit, sts_i.out_free, "result issued while result register busy")

endmodule

// File: design/nvpt_datapath.sv
`timescale 1ns / 1ps
`include "nearby_vehicle_proximity_table_unit_defines.svh"

module nvpt_datapath
  import nvpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 8,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic [63:0]      in_data_i,
  input  logic             in_user_i,
  input  cmd_t             cmd_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_data_o
);

  // Configuration registers.
  logic [23:0] near_q, far_q;
  logic [31:0] tmo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= NEAR_LIMIT_RST;
      far_q  <= FAR_LIMIT_RST;
      tmo_q  <= STALE_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NEAR_LIMIT: near_q <= cfg_data_i[23:0];
        CFG_FAR_LIMIT:  far_q  <= cfg_data_i[23:0];
        CFG_STALE_TMO:  tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured input item.
  logic        op_q;
  logic [31:0] now_q;
  logic [7:0]  vid_q;
  logic [23:0] dist_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= in_user_i;
      now_q  <= in_data_i[31:0];
      vid_q  <= in_data_i[39:32];
      dist_q <= in_data_i[63:40];
    end
  end

  // Entry storage; occupancy lives in the valid flops, so the array needs no reset.
  entry_t                   mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  entry_t                   rd_q;
  logic                     rd_vld_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     eval_q;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= '{id: vid_q, distance: dist_q, seen: now_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_vld_q <= valid_q[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  logic [23:0]      min_q, min_d;
  logic             match_q, free_q;
  logic [IDX_W-1:0] match_idx_q, free_idx_q;
  logic             dropped_q;
  logic             is_new_report;

  // Scan evaluation of the entry read in the previous cycle.
  logic [31:0] age;
  logic        hit, stale, lower;

  always_comb begin
    age   = now_q - rd_q.seen;
    hit   = eval_q && rd_vld_q && (op_q == OP_REPORT) && (rd_q.id == vid_q);
    stale = eval_q && rd_vld_q && (op_q == OP_SWEEP) && (age > tmo_q);
    lower = eval_q && rd_vld_q && !hit && !stale && (rd_q.distance < min_q);
  end

  // Ids in the table are unique, so excluding every match excludes exactly the entry rewritten.
  assign is_new_report = (op_q == OP_REPORT) && (vid_q != 8'd0);
  assign wr_en   = cmd_i.fold && is_new_report && (match_q || free_q);
  assign wr_addr = match_q ? match_idx_q : free_idx_q;

  always_comb begin
    min_d = min_q;
    if (cmd_i.start) begin
      min_d = NO_VEHICLE_DIST;
    end else if (lower) begin
      min_d = rd_q.distance;
    end else if (wr_en && (dist_q < min_q)) begin
      min_d = dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      eval_q  <= 1'b0;
    end else begin
      eval_q <= cmd_i.rd_en;
      if (stale) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
    if (cmd_i.start) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (hit && !match_q) begin
        match_q     <= 1'b1;
        match_idx_q <= rd_idx_q;
      end
      if (eval_q && !rd_vld_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.fold) begin
      dropped_q <= is_new_report && !match_q && !free_q;
    end
  end

  // Result register.
  logic        out_vld_q;
  logic [23:0] out_min_q;
  logic [1:0]  out_alert_q;
  logic        out_drop_q;
  logic [1:0]  alert;

  always_comb begin
    if (min_q < near_q) begin
      alert = ALERT_NEAR;
    end else if (min_q <= far_q) begin
      alert = ALERT_MID;
    end else begin
      alert = ALERT_FAR;
    end
  end

  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_min_q   <= min_q;
      out_alert_q <= alert;
      out_drop_q  <= dropped_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {5'd0, out_drop_q, out_alert_q, out_min_q};

  `NVP_ASSERT_IMP(a_write_nonzero_id, wr_en, vid_q != 8'd0, "table write with empty id")
  `NVP_ASSERT_IMP(a_drop_only_report, cmd_i.emit && dropped_q, op_q == OP_REPORT, "sweep flagged as dropped")
  `NVP_ASSERT_IMP(a_no_clear_and_write, stale, !wr_en, "entry cleared and written in one cycle")
  `NVP_ASSERT_IMP(a_alert_legal, out_vld_q, out_alert_q != 2'd3, "illegal alert level")

endmodule

// File: design/nearby_vehicle_proximity_table_unit.sv
`timescale 1ns / 1ps
// A result enters the result register after the scan, drain and fold states, once it is
// free; only then is a new item taken, at a pace set by the single read port of the entry
// table, which is scanned one entry per cycle.
// Reset (rst_ni, asynchronous, active low) empties the table and loads the limits
// with 50, 100 and 12000; no clearing pass follows.

module nearby_vehicle_proximity_table_unit
  import nvpt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration writes: index 0 near_limit, 1 far_limit, 2 stale_timeout_ms.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // now_ms[31:0], vehicle_id[39:32], distance[63:40]
  input  logic        s_axis_tuser,   // op (0 report, 1 sweep)

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // min_distance[23:0], alert_level[25:24], dropped[26]
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] rd_addr;

  // The controller walks the table once per item: every entry is read, a report finds
  // its matching or first empty entry, a sweep clears aged entries, and the minimum
  // distance is gathered on the way. The report write and the result follow the scan.
  nvpt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  // The datapath holds the table, the limits and a result register, so the result of
  // one transaction can wait for the sink while the next item is already taken in.
  nvpt_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .sts_o      (sts),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule
